@@ hw/rtl/pdcc_pkg.sv @@
// Shared types and constants for the packet deframer with checksum check.
// Used by every module of the block; no dependencies of its own.
package pdcc_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 16;
	localparam int MAXP_W   = 12;
	localparam int LIMIT_W  = 17;
	localparam int HDR_BYTES = 6;

	localparam logic [1:0] ST_BUSY     = 2'd0;
	localparam logic [1:0] ST_OK       = 2'd1;
	localparam logic [1:0] ST_BAD_SUM  = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	localparam logic [2:0] HP_CMD    = 3'd0;
	localparam logic [2:0] HP_SRC    = 3'd1;
	localparam logic [2:0] HP_DST    = 3'd2;
	localparam logic [2:0] HP_SUM    = 3'd3;
	localparam logic [2:0] HP_LEN_HI = 3'd4;
	localparam logic [2:0] HP_LEN_LO = 3'd5;

	localparam logic REG_MAX_PAYLOAD = 1'b0;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              is_last;
		logic [1:0]        status;
		logic [BYTE_W-1:0] command;
		logic [BYTE_W-1:0] source_addr;
		logic [BYTE_W-1:0] dest_addr;
		logic [LEN_W-1:0]  payload_len;
	} res_t;

endpackage

@@ hw/rtl/packet_deframe_checksum_check_unit.sv @@
// Packet deframer with 8-bit additive checksum check, top level.
// Depends on pdcc_pkg, pdcc_cfg_regs, pdcc_parser and pdcc_out_reg.
//
// Input channel (in_valid/in_stall/rx_byte) takes one byte per transaction.
// Each packet is a six-byte header (command, source, destination, checksum,
// length high, length low) followed by the payload. Header bytes give no
// result, except a final length byte that ends the packet (zero length or
// over the limit). Each payload byte gives one result with byte_valid set;
// the last one carries is_last and status ok or checksum mismatch.
// Throughput: one byte per cycle while out_stall is low. A byte waits in
// the input register, then its result in the output register (out_valid).
// The output register holds a result while out_stall is high; the input
// register still takes a byte that causes no result, and in_stall rises
// only when both registers are full. Reset clears the parser to await a
// command byte and sets max_payload to MAX_FRAME - 6 (at most 4095).
// The user writes max_payload over the APB port at address 0 only while
// idle; the block does not enforce it.
module packet_deframe_checksum_check_unit import pdcc_pkg::*; #(
	parameter int MAX_FRAME = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic              is_last,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] command,
	output logic [BYTE_W-1:0] source_addr,
	output logic [BYTE_W-1:0] dest_addr,
	output logic [LEN_W-1:0]  payload_len
);

	logic [LIMIT_W-1:0] limit;
	res_t               res;
	logic               res_valid;
	logic               res_ready;

	pdcc_cfg_regs #(
		.MAX_FRAME(MAX_FRAME)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.limit  (limit)
	);

	pdcc_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.limit    (limit),
		.res      (res),
		.res_valid(res_valid),
		.res_ready(res_ready)
	);

	pdcc_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.is_last    (is_last),
		.status     (status),
		.command    (command),
		.source_addr(source_addr),
		.dest_addr  (dest_addr),
		.payload_len(payload_len)
	);

endmodule

@@ hw/rtl/pdcc_cfg_regs.sv @@
// Configuration register file: APB-style access to max_payload, and output
// of the effective length limit. Depends on pdcc_pkg.
module pdcc_cfg_regs import pdcc_pkg::*; #(
	parameter int MAX_FRAME = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [LIMIT_W-1:0] limit
);

	localparam int CAP = MAX_FRAME - HDR_BYTES;
	localparam logic [MAXP_W-1:0] MAXP_RST =
		(CAP < 4095) ? MAXP_W'(CAP) : {MAXP_W{1'b1}};
	localparam logic [LIMIT_W-1:0] CAP_L = LIMIT_W'(CAP);

	logic [MAXP_W-1:0]  max_payload_q;
	logic [LIMIT_W-1:0] maxp_ext;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAXP_RST;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == REG_MAX_PAYLOAD) begin
			max_payload_q <= pwdata[MAXP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MAX_PAYLOAD) begin
			prdata = {{(32-MAXP_W){1'b0}}, max_payload_q};
		end
	end

	assign maxp_ext = {{(LIMIT_W-MAXP_W){1'b0}}, max_payload_q};
	assign limit    = (maxp_ext < CAP_L) ? maxp_ext : CAP_L;

endmodule

@@ hw/rtl/pdcc_parser.sv @@
// Input register and per-byte frame parser: header capture, length check,
// running checksum and result formation. Depends on pdcc_pkg.
module pdcc_parser import pdcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [BYTE_W-1:0]  rx_byte,
	input  logic [LIMIT_W-1:0] limit,
	output res_t               res,
	output logic               res_valid,
	input  logic               res_ready
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [2:0]        header_pos_q, header_pos_d;
	logic              in_payload_q, in_payload_d;
	logic [BYTE_W-1:0] cmd_q, cmd_d, src_q, src_d, dst_q, dst_d;
	logic [BYTE_W-1:0] sum_exp_q, sum_exp_d, sum_q, sum_d;
	logic [LEN_W-1:0]  len_q, len_d, left_q, left_d;
	logic [1:0]        fin_status;
	logic              has_res;
	logic              fire;
	logic              accept;

	always_comb begin
		header_pos_d = header_pos_q;
		in_payload_d = in_payload_q;
		cmd_d        = cmd_q;
		src_d        = src_q;
		dst_d        = dst_q;
		sum_exp_d    = sum_exp_q;
		len_d        = len_q;
		left_d       = left_q;
		sum_d        = sum_q;
		fin_status   = ST_BUSY;
		has_res      = 1'b0;
		res          = '0;
		if (in_payload_q) begin
			sum_d       = sum_q + byte_s1;
			left_d      = left_q - 1'b1;
			has_res     = 1'b1;
			res.out_byte   = byte_s1;
			res.byte_valid = 1'b1;
			if (left_d == '0) begin
				in_payload_d = 1'b0;
				header_pos_d = HP_CMD;
				fin_status   = (sum_d == sum_exp_q) ? ST_OK : ST_BAD_SUM;
				res.is_last  = 1'b1;
				res.status   = fin_status;
			end else begin
				res.status   = ST_BUSY;
			end
		end else begin
			case (header_pos_q)
				HP_CMD: begin
					cmd_d = byte_s1;
					header_pos_d = HP_SRC;
				end
				HP_SRC: begin
					src_d = byte_s1;
					header_pos_d = HP_DST;
				end
				HP_DST: begin
					dst_d = byte_s1;
					header_pos_d = HP_SUM;
				end
				HP_SUM: begin
					sum_exp_d = byte_s1;
					header_pos_d = HP_LEN_HI;
				end
				HP_LEN_HI: begin
					len_d = {byte_s1, {BYTE_W{1'b0}}};
					header_pos_d = HP_LEN_LO;
				end
				default: begin
					len_d = {len_q[LEN_W-1:BYTE_W], byte_s1};
					header_pos_d = HP_CMD;
					sum_d = cmd_q + src_q + dst_q + byte_s1;
					if ({1'b0, len_d} > limit) begin
						has_res     = 1'b1;
						res.is_last = 1'b1;
						res.status  = ST_TOO_LONG;
					end else if (len_d == '0) begin
						has_res     = 1'b1;
						fin_status  = (sum_d == sum_exp_q) ? ST_OK : ST_BAD_SUM;
						res.is_last = 1'b1;
						res.status  = fin_status;
					end else begin
						left_d       = len_d;
						in_payload_d = 1'b1;
					end
				end
			endcase
		end
		res.command     = cmd_d;
		res.source_addr = src_d;
		res.dest_addr   = dst_d;
		res.payload_len = len_d;
	end

	assign fire      = valid_s1 && (!has_res || res_ready);
	assign res_valid = valid_s1 && has_res && res_ready;
	assign in_stall  = valid_s1 && !fire;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_pos_q <= HP_CMD;
			in_payload_q <= 1'b0;
			cmd_q        <= '0;
			src_q        <= '0;
			dst_q        <= '0;
			sum_exp_q    <= '0;
			len_q        <= '0;
			left_q       <= '0;
			sum_q        <= '0;
		end else if (fire) begin
			header_pos_q <= header_pos_d;
			in_payload_q <= in_payload_d;
			cmd_q        <= cmd_d;
			src_q        <= src_d;
			dst_q        <= dst_d;
			sum_exp_q    <= sum_exp_d;
			len_q        <= len_d;
			left_q       <= left_d;
			sum_q        <= sum_d;
		end
	end

endmodule

@@ hw/rtl/pdcc_out_reg.sv @@
// Result register: holds one result transaction until the receiver takes it.
// Depends on pdcc_pkg.
module pdcc_out_reg import pdcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  res_t              res,
	input  logic              res_valid,
	output logic              res_ready,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic              is_last,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] command,
	output logic [BYTE_W-1:0] source_addr,
	output logic [BYTE_W-1:0] dest_addr,
	output logic [LEN_W-1:0]  payload_len
);

	logic valid_s2;
	res_t res_s2;

	assign res_ready = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_ready) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign out_byte    = res_s2.out_byte;
	assign byte_valid  = res_s2.byte_valid;
	assign is_last     = res_s2.is_last;
	assign status      = res_s2.status;
	assign command     = res_s2.command;
	assign source_addr = res_s2.source_addr;
	assign dest_addr   = res_s2.dest_addr;
	assign payload_len = res_s2.payload_len;

endmodule

@@ sim/packet_deframe_checksum_check_unit_tb.sv @@
// Self-checking testbench for the packet deframer with checksum check.
// Depends on pdcc_pkg and packet_deframe_checksum_check_unit; predicts every
// result from the accepted byte stream and compares it field by field.
`timescale 1ns / 100ps

module packet_deframe_checksum_check_unit_tb;
	import pdcc_pkg::*;

	localparam int FRAME_MAX = 4096;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 100;
	localparam int IDLE_PCT = 34;
	localparam int LIMIT_LEN = 40;
	localparam logic [2:0] ADDR_MAX_PAYLOAD = 3'(4 * REG_MAX_PAYLOAD);
	localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte;
	logic              out_valid;
	logic              out_stall;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_valid;
	logic              is_last;
	logic [1:0]        status;
	logic [BYTE_W-1:0] command;
	logic [BYTE_W-1:0] source_addr;
	logic [BYTE_W-1:0] dest_addr;
	logic [LEN_W-1:0]  payload_len;

	logic [BYTE_W-1:0] rx_pending[$];
	res_t              results_due[$];
	int                queued_cnt;
	int                accepted_cnt;
	int                mismatch_cnt;
	int                cycle_cnt;
	int                hold_left;
	bit                pressure_done;
	bit                calm;

	logic [MAXP_W-1:0] max_len_cfg;
	logic [2:0]        hdr_idx;
	logic              in_body;
	logic [7:0]        cmd_r;
	logic [7:0]        src_r;
	logic [7:0]        dst_r;
	logic [7:0]        sum_want;
	logic [15:0]       len_r;
	logic [15:0]       body_left;
	logic [7:0]        sum_acc;

	packet_deframe_checksum_check_unit #(
		.MAX_FRAME(FRAME_MAX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.is_last(is_last),
		.status(status),
		.command(command),
		.source_addr(source_addr),
		.dest_addr(dest_addr),
		.payload_len(payload_len)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [16:0] frame_limit();
		logic [16:0] cap;
		cap = 17'(FRAME_MAX - HDR_BYTES);
		return (17'(max_len_cfg) < cap) ? 17'(max_len_cfg) : cap;
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		res_t r;
		bit   emit;
		r = '0;
		emit = 1'b0;
		if (in_body) begin
			sum_acc = sum_acc + b;
			body_left = body_left - 16'd1;
			r.out_byte = b;
			r.byte_valid = 1'b1;
			r.status = ST_BUSY;
			if (body_left == 16'd0) begin
				in_body = 1'b0;
				hdr_idx = HP_CMD;
				r.is_last = 1'b1;
				r.status = (sum_acc == sum_want) ? ST_OK : ST_BAD_SUM;
			end
			emit = 1'b1;
		end else begin
			case (hdr_idx)
				HP_CMD: begin
					cmd_r = b;
					hdr_idx = HP_SRC;
				end
				HP_SRC: begin
					src_r = b;
					hdr_idx = HP_DST;
				end
				HP_DST: begin
					dst_r = b;
					hdr_idx = HP_SUM;
				end
				HP_SUM: begin
					sum_want = b;
					hdr_idx = HP_LEN_HI;
				end
				HP_LEN_HI: begin
					len_r = {b, 8'h00};
					hdr_idx = HP_LEN_LO;
				end
				default: begin
					len_r[7:0] = b;
					hdr_idx = HP_CMD;
					sum_acc = cmd_r + src_r + dst_r + b;
					if (17'(len_r) > frame_limit()) begin
						r.is_last = 1'b1;
						r.status = ST_TOO_LONG;
						emit = 1'b1;
					end else if (len_r == 16'd0) begin
						r.is_last = 1'b1;
						r.status = (sum_acc == sum_want) ? ST_OK : ST_BAD_SUM;
						emit = 1'b1;
					end else begin
						body_left = len_r;
						in_body = 1'b1;
					end
				end
			endcase
		end
		if (emit) begin
			r.command = cmd_r;
			r.source_addr = src_r;
			r.dest_addr = dst_r;
			r.payload_len = len_r;
			results_due.push_back(r);
		end
	endtask

	task automatic check_field(input string fname, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("mismatch %s: expected %0h, got %0h at cycle %0d",
					fname, want, got, cycle_cnt);
		end
	endtask

	task automatic push_rx(input logic [7:0] b);
		rx_pending.push_back(b);
		queued_cnt++;
	endtask

	task automatic queue_packet(input logic [7:0] c, input logic [7:0] s, input logic [7:0] d,
			input logic [15:0] len, input int nbody, input bit good_sum);
		logic [7:0] body[$];
		logic [7:0] sum;
		logic [7:0] pb;
		int         i;
		sum = c + s + d + len[7:0];
		for (i = 0; i < nbody; i++) begin
			pb = 8'($urandom);
			body.push_back(pb);
			sum = sum + pb;
		end
		if (!good_sum)
			sum = sum + 8'($urandom_range(1, 255));
		push_rx(c);
		push_rx(s);
		push_rx(d);
		push_rx(sum);
		push_rx(len[15:8]);
		push_rx(len[7:0]);
		foreach (body[k])
			push_rx(body[k]);
	endtask

	task automatic random_packets(input int n_items);
		int          start_cnt;
		int          pick;
		int          n;
		logic [16:0] lim;
		logic [15:0] len;
		start_cnt = queued_cnt;
		lim = frame_limit();
		while (queued_cnt - start_cnt < n_items) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				n = $urandom_range(1, 4);
				repeat (n) push_rx(8'($urandom));
			end else if (pick < 18) begin
				if ($urandom_range(1))
					len = 16'(lim + 1);
				else
					len = 16'($urandom_range(int'(lim) + 1, 65535));
				queue_packet(8'($urandom), 8'($urandom), 8'($urandom), len, 0,
					1'($urandom_range(1)));
			end else begin
				if (lim <= 24)
					len = 16'($urandom_range(0, int'(lim)));
				else
					len = 16'($urandom_range(0, 24));
				queue_packet(8'($urandom), 8'($urandom), 8'($urandom), len, int'(len),
					$urandom_range(99) < 85);
			end
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (rx_pending.size() != 0 || in_valid || results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_MAX_PAYLOAD)
			max_len_cfg = data[MAXP_W-1:0];
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		out_stall = 1'b0;
		queued_cnt = 0;
		accepted_cnt = 0;
		mismatch_cnt = 0;
		cycle_cnt = 0;
		hold_left = 0;
		pressure_done = 1'b0;
		max_len_cfg = MAXP_W'(FRAME_MAX - HDR_BYTES);
		hdr_idx = HP_CMD;
		in_body = 1'b0;
		cmd_r = '0;
		src_r = '0;
		dst_r = '0;
		sum_want = '0;
		len_r = '0;
		body_left = '0;
		sum_acc = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		queue_packet(8'hFF, 8'h00, 8'hFF, 16'd0, 0, 1'b1);
		queue_packet(8'h00, 8'hFF, 8'h00, 16'd0, 0, 1'b0);
		queue_packet(8'hA5, 8'h5A, 8'h3C, 16'd2, 2, 1'b1);
		queue_packet(8'h01, 8'h02, 8'h03, 16'hFFFF, 0, 1'b1);
		wait_idle();

		apb_write(ADDR_UNMAPPED, 32'd0);
		queue_packet(8'($urandom), 8'($urandom), 8'($urandom), 16'(frame_limit() + 1), 0, 1'b1);
		random_packets(60);
		wait_idle();

		apb_write(ADDR_MAX_PAYLOAD, 32'd0);
		random_packets(120);
		wait_idle();

		apb_write(ADDR_MAX_PAYLOAD, 32'hFFFF_F005);
		random_packets(120);
		wait_idle();

		apb_write(ADDR_MAX_PAYLOAD, 32'hFFFF_FFFF);
		random_packets(120);
		wait_idle();

		apb_write(ADDR_MAX_PAYLOAD, 32'd37);
		random_packets(120);
		wait_idle();

		apb_write(ADDR_MAX_PAYLOAD, 32'(LIMIT_LEN));
		random_packets(40);
		queue_packet(8'($urandom), 8'($urandom), 8'($urandom), 16'(LIMIT_LEN),
			LIMIT_LEN, 1'b1);
		random_packets(40);
		wait_idle();

		if (mismatch_cnt == 0 && results_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	assign calm = (accepted_cnt >= 300) && (accepted_cnt < 450);

	// drive the byte stream; hold the payload while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				deframe_byte(rx_byte);
				accepted_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (rx_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					rx_byte <= rx_pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off inside a payload
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!pressure_done && accepted_cnt > 60 && in_body && body_left > 16'd20) begin
				hold_left <= HOLD_CYCLES;
				pressure_done <= 1'b1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected transaction: out_byte %0h status %0d at cycle %0d",
						out_byte, status, cycle_cnt);
			end else begin
				want = results_due.pop_front();
				check_field("out_byte", 16'(want.out_byte), 16'(out_byte));
				check_field("byte_valid", 16'(want.byte_valid), 16'(byte_valid));
				check_field("is_last", 16'(want.is_last), 16'(is_last));
				check_field("status", 16'(want.status), 16'(status));
				check_field("command", 16'(want.command), 16'(command));
				check_field("source_addr", 16'(want.source_addr), 16'(source_addr));
				check_field("dest_addr", 16'(want.dest_addr), 16'(dest_addr));
				check_field("payload_len", want.payload_len, payload_len);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

@@ packet_deframe_checksum_check_unit.f @@
hw/rtl/pdcc_pkg.sv
hw/rtl/pdcc_cfg_regs.sv
hw/rtl/pdcc_parser.sv
hw/rtl/pdcc_out_reg.sv
hw/rtl/packet_deframe_checksum_check_unit.sv
sim/packet_deframe_checksum_check_unit_tb.sv
